@@ hdl/irpd_pkg.sv @@
package irpd_pkg;

    // Field widths of the two channels and of the configuration port.
    localparam int FUNC_W    = 2;
    localparam int PULSE_W   = 16;
    localparam int KEY_W     = 7;
    localparam int REPEAT_W  = 8;
    localparam int IDLE_W    = 4;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;
    localparam int OUT_DATA_W = 24;

    // Event kinds as they arrive on the input channel.
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RISE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FALL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SCAN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_KEY_ONE    = 8'd176;
    localparam logic [CFG_W-1:0] RST_KEY_TWO    = 8'd48;
    localparam logic [CFG_W-1:0] RST_KEY_THREE  = 8'd168;
    localparam logic [CFG_W-1:0] RST_KEY_FOUR   = 8'd0;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS = 8'd10;

    // Default depth of the event queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Classified event carried through the queue.
    typedef enum logic [2:0] {
        EV_TICK,
        EV_RISE,
        EV_FALL_NONE,
        EV_FALL_ZERO,
        EV_FALL_ONE,
        EV_FALL_REPEAT,
        EV_FALL_LEADER,
        EV_SCAN
    } t_evt;

    typedef struct packed {
        logic [CFG_W-1:0] key_one;
        logic [CFG_W-1:0] key_two;
        logic [CFG_W-1:0] key_three;
        logic [CFG_W-1:0] key_four;
        logic [CFG_W-1:0] long_press;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

@@ hdl/irpd_front.sv @@
module irpd_front (
    input  logic                          i_tvalid,
    input  logic [irpd_pkg::FUNC_W-1:0]   i_func,
    input  logic [irpd_pkg::PULSE_W-1:0]  i_pulse_us,
    input  irpd_pkg::t_q_status           i_q_status,
    output logic                          o_tready,
    output logic                          o_push,
    output irpd_pkg::t_evt                o_evt
);

    localparam logic [irpd_pkg::PULSE_W-1:0] ZERO_LO   = 16'd300;
    localparam logic [irpd_pkg::PULSE_W-1:0] ZERO_HI   = 16'd800;
    localparam logic [irpd_pkg::PULSE_W-1:0] ONE_LO    = 16'd1400;
    localparam logic [irpd_pkg::PULSE_W-1:0] ONE_HI    = 16'd1800;
    localparam logic [irpd_pkg::PULSE_W-1:0] REPEAT_LO = 16'd2200;
    localparam logic [irpd_pkg::PULSE_W-1:0] REPEAT_HI = 16'd2600;
    localparam logic [irpd_pkg::PULSE_W-1:0] LEADER_LO = 16'd4200;
    localparam logic [irpd_pkg::PULSE_W-1:0] LEADER_HI = 16'd4700;

    irpd_pkg::t_evt fall_evt;

    assign o_tready = !i_q_status.full;
    assign o_push   = i_tvalid && !i_q_status.full;

    // Sort the pulse width into its window; the back end decides what it means.
    always_comb begin
        if (i_pulse_us > ZERO_LO && i_pulse_us < ZERO_HI) begin
            fall_evt = irpd_pkg::EV_FALL_ZERO;
        end else if (i_pulse_us > ONE_LO && i_pulse_us < ONE_HI) begin
            fall_evt = irpd_pkg::EV_FALL_ONE;
        end else if (i_pulse_us > REPEAT_LO && i_pulse_us < REPEAT_HI) begin
            fall_evt = irpd_pkg::EV_FALL_REPEAT;
        end else if (i_pulse_us > LEADER_LO && i_pulse_us < LEADER_HI) begin
            fall_evt = irpd_pkg::EV_FALL_LEADER;
        end else begin
            fall_evt = irpd_pkg::EV_FALL_NONE;
        end
    end

    always_comb begin
        unique case (i_func)
            irpd_pkg::FUNC_TICK: o_evt = irpd_pkg::EV_TICK;
            irpd_pkg::FUNC_RISE: o_evt = irpd_pkg::EV_RISE;
            irpd_pkg::FUNC_FALL: o_evt = fall_evt;
            irpd_pkg::FUNC_SCAN: o_evt = irpd_pkg::EV_SCAN;
            default:             o_evt = irpd_pkg::EV_SCAN;
        endcase
    end

endmodule

@@ hdl/irpd_queue.sv @@
module irpd_queue #(
    parameter int DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  irpd_pkg::t_evt      i_evt,
    input  logic                i_pop,
    output irpd_pkg::t_evt      o_evt,
    output irpd_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    irpd_pkg::t_evt   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    assign o_evt           = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == CNT_W'(DEPTH));

endmodule

@@ hdl/irpd_back.sv @@
module irpd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  irpd_pkg::t_cfg                      i_cfg,
    input  irpd_pkg::t_evt                      i_evt,
    input  irpd_pkg::t_q_status                 i_q_status,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [irpd_pkg::OUT_DATA_W-1:0]     o_tdata
);

    localparam logic [irpd_pkg::IDLE_W-1:0]   IDLE_LIMIT = 4'd14;
    localparam logic [irpd_pkg::REPEAT_W-1:0] REPEAT_MAX = 8'hFF;
    localparam logic [irpd_pkg::KEY_W-1:0]    HELD_BIT   = 7'h20;
    localparam logic [irpd_pkg::KEY_W-1:0]    LONG_BIT   = 7'h40;
    localparam logic [irpd_pkg::KEY_W-1:0]    KEY_MASK   = 7'h0F;
    localparam logic [7:0] CMD_ONE   = 8'hB0;
    localparam logic [7:0] CMD_TWO   = 8'h30;
    localparam logic [7:0] CMD_THREE = 8'hA8;
    localparam logic [7:0] CMD_FOUR  = 8'h00;
    localparam logic [7:0] CMD_FIVE  = 8'h18;
    localparam logic [irpd_pkg::KEY_W-1:0] KEY_ONE   = 7'h11;
    localparam logic [irpd_pkg::KEY_W-1:0] KEY_TWO   = 7'h12;
    localparam logic [irpd_pkg::KEY_W-1:0] KEY_THREE = 7'h13;
    localparam logic [irpd_pkg::KEY_W-1:0] KEY_FOUR  = 7'h14;
    localparam logic [irpd_pkg::KEY_W-1:0] KEY_FIVE  = 7'h15;

    logic [irpd_pkg::WORD_W-1:0]   r_word,   n_word;
    logic                          r_leader, n_leader;
    logic                          r_ready,  n_ready;
    logic                          r_high,   n_high;
    logic                          r_hold,   n_hold;
    logic [irpd_pkg::IDLE_W-1:0]   r_idle,   n_idle;
    logic [irpd_pkg::REPEAT_W-1:0] r_repeat, n_repeat;
    logic [irpd_pkg::KEY_W-1:0]    r_key,    n_key;

    logic                              r_out_valid;
    logic [irpd_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic [7:0] addr, addr_inv, cmd, cmd_inv;
    logic       frame_ok;

    assign addr     = r_word[31:24];
    assign addr_inv = r_word[23:16];
    assign cmd      = r_word[15:8];
    assign cmd_inv  = r_word[7:0];
    assign frame_ok = (addr == ~addr_inv) && (cmd == ~cmd_inv);

    // The next event is taken whenever the output register is free or drains now.
    assign o_pop = !i_q_status.empty && (!r_out_valid || i_tready);

    always_comb begin
        n_word   = r_word;
        n_leader = r_leader;
        n_ready  = r_ready;
        n_high   = r_high;
        n_hold   = r_hold;
        n_idle   = r_idle;
        n_repeat = r_repeat;
        n_key    = r_key;
        unique case (i_evt)
            irpd_pkg::EV_TICK: begin
                if (r_leader) begin
                    n_high = 1'b0;
                    if (r_idle == '0) begin
                        n_ready = 1'b1;
                    end
                    if (r_idle < IDLE_LIMIT) begin
                        n_idle = r_idle + irpd_pkg::IDLE_W'(1);
                    end else begin
                        n_leader = 1'b0;
                        n_idle   = '0;
                    end
                end
            end
            irpd_pkg::EV_RISE: begin
                n_high = 1'b1;
            end
            irpd_pkg::EV_FALL_ZERO: begin
                if (r_high && r_leader) begin
                    n_word = {r_word[irpd_pkg::WORD_W-2:0], 1'b0};
                end
                n_high = 1'b0;
            end
            irpd_pkg::EV_FALL_ONE: begin
                if (r_high && r_leader) begin
                    n_word = {r_word[irpd_pkg::WORD_W-2:0], 1'b1};
                end
                n_high = 1'b0;
            end
            irpd_pkg::EV_FALL_REPEAT: begin
                if (r_high && r_leader) begin
                    if (r_repeat != REPEAT_MAX) begin
                        n_repeat = r_repeat + irpd_pkg::REPEAT_W'(1);
                    end
                    n_idle = '0;
                end
                n_high = 1'b0;
            end
            irpd_pkg::EV_FALL_LEADER: begin
                if (r_high && !r_leader) begin
                    n_leader = 1'b1;
                    n_repeat = '0;
                end
                n_high = 1'b0;
            end
            irpd_pkg::EV_FALL_NONE: begin
                n_high = 1'b0;
            end
            irpd_pkg::EV_SCAN: begin
                if (r_ready) begin
                    if (frame_ok) begin
                        if (!r_hold) begin
                            n_hold = 1'b1;
                            if (cmd == CMD_ONE || cmd == i_cfg.key_one) begin
                                n_key = KEY_ONE;
                            end else if (cmd == CMD_TWO || cmd == i_cfg.key_two) begin
                                n_key = KEY_TWO;
                            end else if (cmd == CMD_THREE || cmd == i_cfg.key_three) begin
                                n_key = KEY_THREE;
                            end else if (cmd == CMD_FOUR || cmd == i_cfg.key_four) begin
                                n_key = KEY_FOUR;
                            end else if (cmd == CMD_FIVE) begin
                                n_key = KEY_FIVE;
                            end
                        end else begin
                            n_key = r_key | HELD_BIT;
                        end
                        if (r_repeat >= i_cfg.long_press) begin
                            n_key = n_key | LONG_BIT;
                        end
                    end
                    // Release: a bad frame, a zero inverted command or a lost leader.
                    if (!frame_ok || cmd_inv == '0 || !r_leader) begin
                        n_ready  = 1'b0;
                        n_repeat = '0;
                        n_word   = '0;
                        n_key    = n_key & KEY_MASK;
                        n_hold   = 1'b0;
                    end
                end
            end
            default: begin
                n_high = r_high;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_leader    <= 1'b0;
            r_ready     <= 1'b0;
            r_high      <= 1'b0;
            r_hold      <= 1'b0;
            r_idle      <= '0;
            r_repeat    <= '0;
            r_key       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_word      <= n_word;
                r_leader    <= n_leader;
                r_ready     <= n_ready;
                r_high      <= n_high;
                r_hold      <= n_hold;
                r_idle      <= n_idle;
                r_repeat    <= n_repeat;
                r_key       <= n_key;
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {7'd0, n_repeat, n_leader, n_ready, n_key};
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

endmodule

@@ hdl/ir_remote_pulse_decoder.sv @@
// NEC-style infrared remote decoder. Every input transfer is one event: a 10 ms tick,
// a rising edge, a falling edge whose tdata carries the measured high time in
// microseconds, or a scan request; tuser says which. A 4.5 ms leader arms reception,
// 0.56 ms and 1.68 ms pulses shift in the 32 frame bits, 2.5 ms pulses count repeat
// codes, and 15 idle ticks end the frame. A scan checks the address and command
// complements and maps the command byte onto a key number with new, held and
// long-press bits. Every event produces exactly one output transfer that reports
// the key status, the frame-ready and leader flags and the repeat count after the
// event. The block takes one event per clock cycle unless output back-pressure fills
// the event queue; each event passes from the front-end classifier into the event
// queue and then through the state update in the back end that loads the output
// register. Configuration writes take effect on the next edge and are meant to be
// made while no events are in flight.
module ir_remote_pulse_decoder #(
    parameter int QUEUE_DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits 15..0: pulse_us.
    input  logic [15:0] s_axis_tdata,
    // Bits 1..0: func.
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits 6..0: key_status, bit 7: frame_ready, bit 8: leader_seen,
    // bits 16..9: repeat_total, bits 23..17: zero.
    output logic [23:0] m_axis_tdata,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    irpd_pkg::t_cfg      r_cfg;
    irpd_pkg::t_evt      w_front_evt;
    irpd_pkg::t_evt      w_queue_evt;
    irpd_pkg::t_q_status w_q_status;
    logic                w_push;
    logic                w_pop;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_one    <= irpd_pkg::RST_KEY_ONE;
            r_cfg.key_two    <= irpd_pkg::RST_KEY_TWO;
            r_cfg.key_three  <= irpd_pkg::RST_KEY_THREE;
            r_cfg.key_four   <= irpd_pkg::RST_KEY_FOUR;
            r_cfg.long_press <= irpd_pkg::RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                irpd_pkg::CFG_KEY_ONE:    r_cfg.key_one    <= i_cfg_data;
                irpd_pkg::CFG_KEY_TWO:    r_cfg.key_two    <= i_cfg_data;
                irpd_pkg::CFG_KEY_THREE:  r_cfg.key_three  <= i_cfg_data;
                irpd_pkg::CFG_KEY_FOUR:   r_cfg.key_four   <= i_cfg_data;
                irpd_pkg::CFG_LONG_PRESS: r_cfg.long_press <= i_cfg_data;
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    // The front end sorts each event, including the pulse-width window of a
    // falling edge, so the back end only has to look at the decoded kind.
    irpd_front u_front (
        .i_tvalid   (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_pulse_us (s_axis_tdata),
        .i_q_status (w_q_status),
        .o_tready   (s_axis_tready),
        .o_push     (w_push),
        .o_evt      (w_front_evt)
    );

    // A short queue decouples input acceptance from output back-pressure.
    irpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_evt    (w_front_evt),
        .i_pop    (w_pop),
        .o_evt    (w_queue_evt),
        .o_status (w_q_status)
    );

    // The back end owns all decoder state and the output register.
    irpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_evt      (w_queue_evt),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

    // The queue can never report full and empty at once.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("event queue reports full and empty together");

    // An event pushed into an empty queue that is not drained must be visible next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_q_status.empty && !w_pop) |=> !w_q_status.empty)
        else $error("pushed event did not reach the queue");

    // Every event taken by the back end yields a result on the next cycle.
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> m_axis_tvalid)
        else $error("consumed event produced no output transfer");

endmodule

@@ bench/tb_top.sv @@
module tb_top;

    // Widths taken over from the package.
    localparam int FUNC_W     = irpd_pkg::FUNC_W;
    localparam int PULSE_W    = irpd_pkg::PULSE_W;
    localparam int KEY_W      = irpd_pkg::KEY_W;
    localparam int REPEAT_W   = irpd_pkg::REPEAT_W;
    localparam int IDLE_W     = irpd_pkg::IDLE_W;
    localparam int WORD_W     = irpd_pkg::WORD_W;
    localparam int CFG_IDX_W  = irpd_pkg::CFG_IDX_W;
    localparam int CFG_W      = irpd_pkg::CFG_W;
    localparam int OUT_DATA_W = irpd_pkg::OUT_DATA_W;

    // A run that goes this many cycles without a transfer on either channel is hung.
    localparam int STALL_LIMIT  = 4000;
    // Padding after the last result, to let the pipeline settle.
    localparam int DRAIN_PAD    = 4;
    localparam int MAX_REPORTED = 10;
    localparam int IDLE_LIMIT   = 14;
    localparam int CFG_SLOTS    = 1 << CFG_IDX_W;

    // Pulse windows in microseconds. The bounds themselves lie outside each window.
    localparam logic [PULSE_W-1:0] ZERO_LO   = 16'd300;
    localparam logic [PULSE_W-1:0] ZERO_HI   = 16'd800;
    localparam logic [PULSE_W-1:0] ONE_LO    = 16'd1400;
    localparam logic [PULSE_W-1:0] ONE_HI    = 16'd1800;
    localparam logic [PULSE_W-1:0] REPEAT_LO = 16'd2200;
    localparam logic [PULSE_W-1:0] REPEAT_HI = 16'd2600;
    localparam logic [PULSE_W-1:0] LEADER_LO = 16'd4200;
    localparam logic [PULSE_W-1:0] LEADER_HI = 16'd4700;

    // Fixed command bytes and the key numbers they select.
    localparam logic [7:0] CMD_KEY_ONE   = 8'hB0;
    localparam logic [7:0] CMD_KEY_TWO   = 8'h30;
    localparam logic [7:0] CMD_KEY_THREE = 8'hA8;
    localparam logic [7:0] CMD_KEY_FOUR  = 8'h00;
    localparam logic [7:0] CMD_KEY_FIVE  = 8'h18;
    localparam logic [KEY_W-1:0] NUM_KEY_ONE   = 7'h11;
    localparam logic [KEY_W-1:0] NUM_KEY_TWO   = 7'h12;
    localparam logic [KEY_W-1:0] NUM_KEY_THREE = 7'h13;
    localparam logic [KEY_W-1:0] NUM_KEY_FOUR  = 7'h14;
    localparam logic [KEY_W-1:0] NUM_KEY_FIVE  = 7'h15;
    localparam logic [KEY_W-1:0] HELD_BIT      = 7'h20;
    localparam logic [KEY_W-1:0] LONG_BIT      = 7'h40;
    localparam logic [KEY_W-1:0] KEY_NUM_MASK  = 7'h0F;

    // Widths that sit on or right next to every window edge, for noise events.
    localparam logic [PULSE_W-1:0] EDGE_WIDTHS [18] = '{
        16'd0,
        ZERO_LO, ZERO_LO + 16'd1, ZERO_HI - 16'd1, ZERO_HI,
        ONE_LO, ONE_LO + 16'd1, ONE_HI - 16'd1, ONE_HI,
        REPEAT_LO, REPEAT_LO + 16'd1, REPEAT_HI - 16'd1, REPEAT_HI,
        LEADER_LO, LEADER_LO + 16'd1, LEADER_HI - 16'd1, LEADER_HI,
        16'hFFFF
    };

    // One result as it sits in the low bits of the output tdata.
    typedef struct packed {
        logic [REPEAT_W-1:0] repeats;
        logic                leader;
        logic                ready;
        logic [KEY_W-1:0]    key;
    } t_key_report;

    // One row of the directed table. A typed row carries its own expected report.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PULSE_W-1:0] width;
        logic               typed;
        t_key_report        report;
    } t_dir_row;

    localparam t_key_report REPORT_IDLE   = '0;
    localparam t_key_report REPORT_LEADER = '{repeats: '0, leader: 1'b1, ready: 1'b0, key: '0};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Bits 15..0: pulse_us.
    logic [PULSE_W-1:0]    s_axis_tdata  = '0;
    // Bits 1..0: func.
    logic [FUNC_W-1:0]     s_axis_tuser  = '0;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Bits 6..0: key_status, bit 7: frame_ready, bit 8: leader_seen,
    // bits 16..9: repeat_total, bits 23..17: zero.
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;

    // The typed expectation rides along with the input data, so the monitor sees
    // exactly the row that belongs to the transfer it is looking at.
    logic        row_typed  = 1'b0;
    t_key_report row_report = '0;

    // Decoder state as the bench predicts it, with its own copy of the registers.
    irpd_pkg::t_cfg      press_cfg;
    logic [WORD_W-1:0]   frame_bits;
    logic                leader_armed;
    logic                frame_waiting;
    logic                pulse_high;
    logic                key_held;
    logic [IDLE_W-1:0]   idle_count;
    logic [REPEAT_W-1:0] repeat_tally;
    logic [KEY_W-1:0]    key_state;

    t_key_report pending_reports[$];
    int unsigned events_sent   = 0;
    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    ir_remote_pulse_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Applies one event to the predicted decoder state and returns the report the
    // block must produce for it.
    function automatic t_key_report decode_event(input logic [FUNC_W-1:0] func,
                                                 input logic [PULSE_W-1:0] width);
        logic [7:0] addr, addr_inv, cmd, cmd_inv;
        logic       frame_ok;
        case (func)
            irpd_pkg::FUNC_TICK: begin
                // Ticks only age a frame that has a leader behind it.
                if (leader_armed) begin
                    pulse_high = 1'b0;
                    if (idle_count == '0) frame_waiting = 1'b1;
                    if (idle_count < IDLE_LIMIT) begin
                        idle_count = idle_count + 1'b1;
                    end else begin
                        leader_armed = 1'b0;
                        idle_count   = '0;
                    end
                end
            end
            irpd_pkg::FUNC_RISE: pulse_high = 1'b1;
            irpd_pkg::FUNC_FALL: begin
                if (pulse_high) begin
                    if (leader_armed) begin
                        if (width > ZERO_LO && width < ZERO_HI) begin
                            frame_bits = {frame_bits[WORD_W-2:0], 1'b0};
                        end else if (width > ONE_LO && width < ONE_HI) begin
                            frame_bits = {frame_bits[WORD_W-2:0], 1'b1};
                        end else if (width > REPEAT_LO && width < REPEAT_HI) begin
                            if (repeat_tally != '1) repeat_tally = repeat_tally + 1'b1;
                            idle_count = '0;
                        end
                    end else if (width > LEADER_LO && width < LEADER_HI) begin
                        leader_armed = 1'b1;
                        repeat_tally = '0;
                    end
                end
                pulse_high = 1'b0;
            end
            irpd_pkg::FUNC_SCAN: begin
                if (frame_waiting) begin
                    {addr, addr_inv, cmd, cmd_inv} = frame_bits;
                    frame_ok = (addr == ~addr_inv) && (cmd == ~cmd_inv);
                    if (frame_ok) begin
                        if (!key_held) begin
                            // First scan of a press picks the key; the first match wins.
                            key_held = 1'b1;
                            if (cmd == CMD_KEY_ONE || cmd == press_cfg.key_one) begin
                                key_state = NUM_KEY_ONE;
                            end else if (cmd == CMD_KEY_TWO || cmd == press_cfg.key_two) begin
                                key_state = NUM_KEY_TWO;
                            end else if (cmd == CMD_KEY_THREE
                                         || cmd == press_cfg.key_three) begin
                                key_state = NUM_KEY_THREE;
                            end else if (cmd == CMD_KEY_FOUR || cmd == press_cfg.key_four) begin
                                key_state = NUM_KEY_FOUR;
                            end else if (cmd == CMD_KEY_FIVE) begin
                                key_state = NUM_KEY_FIVE;
                            end
                        end else begin
                            key_state = key_state | HELD_BIT;
                        end
                        if (repeat_tally >= press_cfg.long_press) key_state = key_state | LONG_BIT;
                    end
                    // A bad frame, an all-zero inverted command or a lost leader
                    // releases the key.
                    if (!frame_ok || cmd_inv == '0 || !leader_armed) begin
                        frame_waiting = 1'b0;
                        repeat_tally  = '0;
                        frame_bits    = '0;
                        key_state     = key_state & KEY_NUM_MASK;
                        key_held      = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return '{repeats: repeat_tally, leader: leader_armed, ready: frame_waiting,
                 key: key_state};
    endfunction

    task automatic note_error(input string what, input logic [OUT_DATA_W-1:0] want,
                              input logic [OUT_DATA_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTED)
            $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, what, want, got);
    endtask

    // Every accepted input is predicted at once; every accepted result is checked
    // against the oldest prediction still waiting.
    always @(posedge i_clk) begin : monitor
        t_key_report predicted, want, got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = decode_event(s_axis_tuser, s_axis_tdata);
                pending_reports.push_back(row_typed ? row_report : predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_key_report)-1:0];
                if (pending_reports.size() == 0) begin
                    note_error("result with nothing pending:", '0, m_axis_tdata);
                end else begin
                    want = pending_reports.pop_front();
                    if (got.key != want.key)
                        note_error("key_status", OUT_DATA_W'(want.key), OUT_DATA_W'(got.key));
                    if (got.ready != want.ready)
                        note_error("frame_ready", OUT_DATA_W'(want.ready),
                                   OUT_DATA_W'(got.ready));
                    if (got.leader != want.leader)
                        note_error("leader_seen", OUT_DATA_W'(want.leader),
                                   OUT_DATA_W'(got.leader));
                    if (got.repeats != want.repeats)
                        note_error("repeat_total", OUT_DATA_W'(want.repeats),
                                   OUT_DATA_W'(got.repeats));
                    if (m_axis_tdata[OUT_DATA_W-1:$bits(t_key_report)] != '0)
                        note_error("pad bits", '0,
                                   OUT_DATA_W'(m_axis_tdata[OUT_DATA_W-1:$bits(t_key_report)]));
                end
            end
        end
    end

    // The receiver holds off at random at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends the run when neither channel has moved for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[ir_remote_pulse_decoder] ERROR");
        $finish;
    end

    // Offers one event, after a random gap, and returns right after the edge at
    // which it was taken. The handshake is judged at the falling edge, where both
    // sides are stable.
    task automatic send_event(input logic [FUNC_W-1:0] func, input logic [PULSE_W-1:0] width,
                              input logic typed = 1'b0, input t_key_report report = '0);
        logic taken;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= width;
        row_typed     <= typed;
        row_report    <= report;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        events_sent++;
    endtask

    task automatic send_pulse(input logic [PULSE_W-1:0] width);
        send_event(irpd_pkg::FUNC_RISE, PULSE_W'($urandom));
        send_event(irpd_pkg::FUNC_FALL, width);
    endtask

    // Picks a width inside an open window, with the values next to the bounds favored.
    function automatic logic [PULSE_W-1:0] pick_width(input logic [PULSE_W-1:0] lo,
                                                      input logic [PULSE_W-1:0] hi);
        case ($urandom_range(4))
            0: return lo + 16'd1;
            1: return hi - 16'd1;
            default: return PULSE_W'($urandom_range(hi - 1, lo + 1));
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(10))
            0: return CMD_KEY_ONE;
            1: return CMD_KEY_TWO;
            2: return CMD_KEY_THREE;
            3: return CMD_KEY_FOUR;
            4: return CMD_KEY_FIVE;
            5: return 8'hFF;
            6: return press_cfg.key_one;
            7: return press_cfg.key_two;
            8: return press_cfg.key_three;
            9: return press_cfg.key_four;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random events of any kind, half of them with a width on or next to a window edge.
    task automatic send_noise(input int count);
        repeat (count) begin
            if ($urandom_range(1))
                send_event(FUNC_W'($urandom_range(irpd_pkg::FUNC_SCAN)),
                           EDGE_WIDTHS[$urandom_range($size(EDGE_WIDTHS) - 1)]);
            else
                send_event(FUNC_W'($urandom_range(irpd_pkg::FUNC_SCAN)), PULSE_W'($urandom));
        end
    endtask

    // One key press: leader, 32 frame bits, scans, a train of repeat codes and
    // usually the idle ticks that end it. Some frames carry a broken complement.
    task automatic send_press(input int repeats, input logic chatty);
        logic [7:0]        addr, cmd;
        logic [WORD_W-1:0] word;
        int                i, r, flip;
        addr = 8'($urandom);
        cmd  = pick_command();
        word = {addr, ~addr, cmd, ~cmd};
        if ($urandom_range(7) == 0) begin
            flip = $urandom_range(WORD_W - 1);
            word[flip] = ~word[flip];
        end
        send_pulse(pick_width(LEADER_LO, LEADER_HI));
        for (i = WORD_W - 1; i >= 0; i--) begin
            if ($urandom_range(39) == 0) send_noise(1);
            send_pulse(word[i] ? pick_width(ONE_LO, ONE_HI) : pick_width(ZERO_LO, ZERO_HI));
        end
        send_event(irpd_pkg::FUNC_TICK, PULSE_W'($urandom));
        send_event(irpd_pkg::FUNC_SCAN, PULSE_W'($urandom));
        for (r = 0; r < repeats; r++) begin
            send_pulse(pick_width(REPEAT_LO, REPEAT_HI));
            if (chatty && $urandom_range(2) == 0)
                send_event(irpd_pkg::FUNC_TICK, PULSE_W'($urandom));
            if (chatty && $urandom_range(1) == 0)
                send_event(irpd_pkg::FUNC_SCAN, PULSE_W'($urandom));
        end
        send_event(irpd_pkg::FUNC_SCAN, PULSE_W'($urandom));
        // Now and then the leader is left armed, so the next press lands on it.
        if ($urandom_range(3) != 0) begin
            repeat ($urandom_range(IDLE_LIMIT + 3, IDLE_LIMIT + 1))
                send_event(irpd_pkg::FUNC_TICK, PULSE_W'($urandom));
            send_event(irpd_pkg::FUNC_SCAN, PULSE_W'($urandom));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = events_sent + count;
        while (events_sent < stop_at) begin
            if ($urandom_range(4) == 0)
                send_noise($urandom_range(8, 1));
            else
                send_press($urandom_range(12), 1'b1);
        end
    endtask

    // Stops offering input and waits until every predicted result has come out,
    // then lets the pipeline settle.
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Writes one register; the caller lowers the write enable after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (index)
            irpd_pkg::CFG_KEY_ONE:    press_cfg.key_one    = value;
            irpd_pkg::CFG_KEY_TWO:    press_cfg.key_two    = value;
            irpd_pkg::CFG_KEY_THREE:  press_cfg.key_three  = value;
            irpd_pkg::CFG_KEY_FOUR:   press_cfg.key_four   = value;
            irpd_pkg::CFG_LONG_PRESS: press_cfg.long_press = value;
            default: ;
        endcase
    endtask

    initial begin : stimulus
        t_dir_row dir_rows [25];
        int       k;
        press_cfg = '{key_one: irpd_pkg::RST_KEY_ONE, key_two: irpd_pkg::RST_KEY_TWO,
                      key_three: irpd_pkg::RST_KEY_THREE, key_four: irpd_pkg::RST_KEY_FOUR,
                      long_press: irpd_pkg::RST_LONG_PRESS};
        frame_bits    = '0;
        leader_armed  = 1'b0;
        frame_waiting = 1'b0;
        pulse_high    = 1'b0;
        key_held      = 1'b0;
        idle_count    = '0;
        repeat_tally  = '0;
        key_state     = '0;

        // Directed events: idle events with nothing armed, leader widths on and
        // just inside the window edges, a falling edge without a rising one, data and
        // repeat widths at their edges, and a scan of a frame that fails its check.
        dir_rows = '{
            '{irpd_pkg::FUNC_TICK, 16'd0,                1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_SCAN, 16'hFFFF,             1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, 16'd4500,             1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, LEADER_LO,            1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'hFFFF,             1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, LEADER_HI,            1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b1, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, LEADER_HI - 16'd1,    1'b1, REPORT_LEADER},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, ZERO_LO,              1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, ZERO_LO + 16'd1,      1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, ONE_HI - 16'd1,       1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, REPEAT_HI,            1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, REPEAT_LO + 16'd1,    1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, 16'd2400,             1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_RISE, 16'd0,                1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_FALL, 16'hFFFF,             1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_TICK, 16'h5555,             1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_SCAN, 16'hAAAA,             1'b0, REPORT_IDLE},
            '{irpd_pkg::FUNC_TICK, 16'd0,                1'b0, REPORT_IDLE}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First phase: the sender stalls now and then, the receiver most of the time.
        send_idle_pct = 13;
        recv_idle_pct = 79;
        for (k = 0; k < $size(dir_rows); k++)
            send_event(dir_rows[k].func, dir_rows[k].width, dir_rows[k].typed,
                       dir_rows[k].report);
        drain_and_settle();
        // One extra code shadows the fixed 0x18 mapping and another repeats a fixed code.
        write_register(irpd_pkg::CFG_KEY_ONE, 8'h5A);
        write_register(irpd_pkg::CFG_KEY_TWO, 8'hC3);
        write_register(irpd_pkg::CFG_KEY_THREE, CMD_KEY_FIVE);
        write_register(irpd_pkg::CFG_KEY_FOUR, CMD_KEY_TWO);
        write_register(irpd_pkg::CFG_LONG_PRESS, 8'd3);
        i_cfg_we <= 1'b0;
        run_random(100);

        // Second phase: the roles swap, and the registers go to their extremes.
        drain_and_settle();
        send_idle_pct = 79;
        recv_idle_pct = 13;
        write_register(irpd_pkg::CFG_KEY_ONE, 8'hFF);
        write_register(irpd_pkg::CFG_KEY_TWO, 8'h00);
        write_register(irpd_pkg::CFG_KEY_THREE, 8'hFF);
        write_register(irpd_pkg::CFG_KEY_FOUR, 8'hFF);
        write_register(irpd_pkg::CFG_LONG_PRESS, 8'd0);
        // Writes to the unused indexes must leave every register alone.
        for (k = int'(irpd_pkg::CFG_LONG_PRESS) + 1; k < CFG_SLOTS; k++)
            write_register(CFG_IDX_W'(k), CFG_W'($urandom));
        i_cfg_we <= 1'b0;
        run_random(100);

        // Third phase: full rate on both sides, a long press that saturates the
        // repeat count, then more random presses.
        drain_and_settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(irpd_pkg::CFG_KEY_ONE, CFG_W'($urandom));
        write_register(irpd_pkg::CFG_KEY_TWO, CFG_W'($urandom));
        write_register(irpd_pkg::CFG_KEY_THREE, CFG_W'($urandom));
        write_register(irpd_pkg::CFG_KEY_FOUR, CFG_W'($urandom));
        write_register(irpd_pkg::CFG_LONG_PRESS, 8'd255);
        i_cfg_we <= 1'b0;
        send_press(258, 1'b0);
        run_random(20);

        drain_and_settle();
        if (error_count == 0)
            $display("[ir_remote_pulse_decoder] OK");
        else
            $display("[ir_remote_pulse_decoder] ERROR");
        $finish;
    end

endmodule
